// ===== sv/poi_pkg.sv =====
package poi_pkg;

  // Field widths of the words on the ports
  localparam int GainW        = 16;
  localparam int SpeedW       = 16;
  localparam int DtW          = 20;
  localparam int AngW         = 32;
  localparam int ScaledW      = 24;
  localparam int CfgIdxW      = 8;
  localparam int PositionBits = 48;

  // Shared multiplier: signed operands and full product
  localparam int MulW  = 34;
  localparam int ProdW = 2 * MulW;

  // CORDIC datapath and step counter
  localparam int CordW   = 34;
  localparam int StepCntW = 6;

  localparam logic [31:0] CordicK  = 32'd652032874;
  localparam logic [31:0] YawK     = 32'd2935890503;
  localparam logic [31:0] HalfTurn = 32'h8000_0000;
  localparam logic [GainW-1:0] GainReset = 16'd256;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_LINEAR_GAIN  = 8'd0;
  localparam logic [CfgIdxW-1:0] CFG_ANGULAR_GAIN = 8'd1;

  typedef struct packed {
    logic signed [SpeedW-1:0] forward_speed;
    logic signed [SpeedW-1:0] lateral_speed;
    logic signed [SpeedW-1:0] yaw_rate;
    logic        [DtW-1:0]    elapsed_time;
  } in_word_t;

  typedef struct packed {
    logic signed [PositionBits-1:0] position_x;
    logic signed [PositionBits-1:0] position_y;
    logic        [AngW-1:0]         heading_angle;
    logic signed [ScaledW-1:0]      scaled_forward;
    logic signed [ScaledW-1:0]      scaled_lateral;
    logic signed [ScaledW-1:0]      scaled_yaw;
    logic                           moving;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CORDIC,
    ST_MUL,
    ST_ACC,
    ST_DONE
  } state_e;

  // Multiply operations, issued in this order
  typedef enum logic [3:0] {
    OP_PX,
    OP_PY,
    OP_PW,
    OP_RX_C,
    OP_RX_S,
    OP_RY_S,
    OP_RY_C,
    OP_DX,
    OP_DY,
    OP_STEP,
    OP_LO,
    OP_HI
  } op_e;

  // Arctangent of 2^-i as a 32-bit binary angle
  function automatic logic [29:0] atan_entry(input logic [4:0] i);
    logic [29:0] r;
    case (i)
      5'd0:    r = 30'h20000000;
      5'd1:    r = 30'h12E4051E;
      5'd2:    r = 30'h09FB385B;
      5'd3:    r = 30'h051111D4;
      5'd4:    r = 30'h028B0D43;
      5'd5:    r = 30'h0145D7E1;
      5'd6:    r = 30'h00A2F61E;
      5'd7:    r = 30'h00517C55;
      5'd8:    r = 30'h0028BE53;
      5'd9:    r = 30'h00145F2F;
      5'd10:   r = 30'h000A2F98;
      5'd11:   r = 30'h000517CC;
      5'd12:   r = 30'h00028BE6;
      5'd13:   r = 30'h000145F3;
      5'd14:   r = 30'h0000A2FA;
      5'd15:   r = 30'h0000517D;
      5'd16:   r = 30'h000028BE;
      5'd17:   r = 30'h0000145F;
      5'd18:   r = 30'h00000A30;
      5'd19:   r = 30'h00000518;
      5'd20:   r = 30'h0000028C;
      5'd21:   r = 30'h00000146;
      5'd22:   r = 30'h000000A3;
      5'd23:   r = 30'h00000051;
      5'd24:   r = 30'h00000029;
      5'd25:   r = 30'h00000014;
      5'd26:   r = 30'h0000000A;
      5'd27:   r = 30'h00000005;
      5'd28:   r = 30'h00000003;
      5'd29:   r = 30'h00000001;
      5'd30:   r = 30'h00000001;
      default: r = 30'h00000000;
    endcase
    return r;
  endfunction

endpackage

// ===== sv/poi_cordic.sv =====
module poi_cordic import poi_pkg::*; #(
  parameter int CordicSteps = 24
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [AngW-1:0]    angle_i,
  output logic               done_o,
  output logic signed [31:0] cos_o,
  output logic signed [31:0] sin_o
);

  localparam logic [StepCntW-1:0] LastStep = StepCntW'(CordicSteps - 1);
  localparam logic signed [CordW-1:0] OneQ30 = CordW'(64'sd1073741824);

  logic signed [CordW-1:0] x_q, y_q, z_q;
  logic [StepCntW-1:0]     cnt_q;
  logic                    run_q, done_q, flip_q;

  logic                    flip;
  logic [AngW-1:0]         folded;
  logic signed [CordW-1:0] xs, ys, at;
  logic signed [CordW-1:0] xc, yc;

  // Fold the angle into the right half plane
  assign flip   = angle_i[31] ^ angle_i[30];
  assign folded = flip ? angle_i - HalfTurn : angle_i;

  assign xs = x_q >>> cnt_q[4:0];
  assign ys = y_q >>> cnt_q[4:0];
  assign at = $signed({4'b0, atan_entry(cnt_q[4:0])});

  // Rotate one step per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == LastStep) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q    <= $signed({2'b0, CordicK});
      y_q    <= '0;
      z_q    <= CordW'($signed(folded));
      flip_q <= flip;
    end else if (run_q) begin
      if (!z_q[CordW-1]) begin
        x_q <= x_q - ys;
        y_q <= y_q + xs;
        z_q <= z_q - at;
      end else begin
        x_q <= x_q + ys;
        y_q <= y_q - xs;
        z_q <= z_q + at;
      end
    end
  end

  // Clamp to unit range and undo the fold
  always_comb begin
    xc = (x_q > OneQ30) ? OneQ30 : ((x_q < -OneQ30) ? -OneQ30 : x_q);
    yc = (y_q > OneQ30) ? OneQ30 : ((y_q < -OneQ30) ? -OneQ30 : y_q);
    if (flip_q) begin
      xc = -xc;
      yc = -yc;
    end
  end

  assign cos_o  = xc[31:0];
  assign sin_o  = yc[31:0];
  assign done_o = done_q;

endmodule

// ===== sv/poi_mul.sv =====
module poi_mul import poi_pkg::*; (
  input  logic                   clk_i,
  input  logic signed [MulW-1:0] a_i,
  input  logic signed [MulW-1:0] b_i,
  output logic signed [ProdW-1:0] prod_o
);

  // Register the full signed product
  always_ff @(posedge clk_i) begin
    prod_o <= ProdW'(a_i) * ProdW'(b_i);
  end

endmodule

// ===== sv/planar_odometry_integrator.sv =====
// Channel   Dir  Handshake                 Word
// in        in   in_valid_i / in_ready_o   in_data_i   (in_word_t)
// out       out  out_valid_o / out_ready_i out_data_o  (out_word_t)
// cfg       in   cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// An accepted word runs one CORDIC step per cycle, then twelve products
// through one shared 34x34 multiplier, each in a ST_MUL and a ST_ACC state
// in turn. in_ready_o is high only while the sequencer is idle. Reset clears
// the pose and loads both gains with 1.0. A stalled result sits in the
// output register; the next word may be accepted meanwhile and waits at its
// end until that register is free. cfg_ready_o is always high.
module planar_odometry_integrator import poi_pkg::*; #(
  parameter int CORDIC_STEPS = 24
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  in_word_t           in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output out_word_t          out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [GainW-1:0]   cfg_data_i
);

  localparam int P = PositionBits;
  localparam logic signed [ProdW-1:0] PosMax = ProdW'({1'b0, {(P-1){1'b1}}});
  localparam logic signed [ProdW-1:0] PosMin = -PosMax - 1;

  state_e state_q, state_d;
  op_e    op_q, op_d;

  in_word_t           in_q;
  logic [GainW-1:0]   lin_gain_q, ang_gain_q;
  logic signed [P-1:0] pos_x_q, pos_y_q;
  logic [AngW-1:0]    heading_q;
  logic signed [32:0] px_q, py_q, pw_q;
  logic signed [ProdW-1:0] acc_q;
  logic signed [33:0] rx_q, ry_q;
  logic signed [54:0] step_q;
  logic [31:0]        lo_q;
  out_word_t          out_q;
  logic               out_valid_q;

  logic               accept, cord_start, cord_done, out_load;
  logic signed [31:0] cos_w, sin_w;
  logic signed [MulW-1:0] mul_a, mul_b;
  logic signed [ProdW-1:0] prod;
  logic [54:0]        mag;
  logic signed [ProdW-1:0] rnd30, dpos, psum, pclamp;
  logic [39:0]        tsum;
  logic [31:0]        dh;

  assign accept      = in_valid_i && in_ready_o;
  assign cord_start  = accept;
  assign cfg_ready_o = 1'b1;

  function automatic logic signed [ScaledW-1:0] scale24(input logic signed [32:0] p);
    logic signed [25:0] r;
    r = 26'((34'(p) + 34'sd128) >>> 8);
    if (r > 26'sd8388607) return 24'sh7FFFFF;
    if (r < -26'sd8388608) return 24'sh800000;
    return r[ScaledW-1:0];
  endfunction

  poi_cordic #(.CordicSteps(CORDIC_STEPS)) u_cordic (
    .clk_i,
    .rst_ni,
    .start_i (cord_start),
    .angle_i (heading_q),
    .done_o  (cord_done),
    .cos_o   (cos_w),
    .sin_o   (sin_w)
  );

  poi_mul u_mul (
    .clk_i,
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  assign mag = step_q[54] ? 55'(-step_q) : 55'(step_q);

  // Select multiplier operands for the current operation
  always_comb begin
    unique case (op_q)
      OP_PX:   begin mul_a = MulW'(in_q.forward_speed); mul_b = $signed({18'b0, lin_gain_q}); end
      OP_PY:   begin mul_a = MulW'(in_q.lateral_speed); mul_b = $signed({18'b0, lin_gain_q}); end
      OP_PW:   begin mul_a = MulW'(in_q.yaw_rate);      mul_b = $signed({18'b0, ang_gain_q}); end
      OP_RX_C: begin mul_a = MulW'(px_q); mul_b = MulW'(cos_w); end
      OP_RX_S: begin mul_a = MulW'(py_q); mul_b = MulW'(sin_w); end
      OP_RY_S: begin mul_a = MulW'(px_q); mul_b = MulW'(sin_w); end
      OP_RY_C: begin mul_a = MulW'(py_q); mul_b = MulW'(cos_w); end
      OP_DX:   begin mul_a = rx_q; mul_b = $signed({14'b0, in_q.elapsed_time}); end
      OP_DY:   begin mul_a = ry_q; mul_b = $signed({14'b0, in_q.elapsed_time}); end
      OP_STEP: begin mul_a = MulW'(pw_q); mul_b = $signed({14'b0, in_q.elapsed_time}); end
      OP_LO:   begin mul_a = $signed({2'b0, mag[31:0]}); mul_b = $signed({2'b0, YawK}); end
      OP_HI:   begin mul_a = $signed({11'b0, mag[54:32]}); mul_b = $signed({2'b0, YawK}); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  // Rounding, position step with saturation, heading step
  always_comb begin
    if (op_q == OP_RX_S) rnd30 = (acc_q - prod + ProdW'(64'sd536870912)) >>> 30;
    else                 rnd30 = (acc_q + prod + ProdW'(64'sd536870912)) >>> 30;
    dpos = (prod + ProdW'(64'sd128)) >>> 8;
    if (op_q == OP_DX) psum = ProdW'(pos_x_q) + dpos;
    else               psum = ProdW'(pos_y_q) + dpos;
    pclamp = (psum > PosMax) ? PosMax : ((psum < PosMin) ? PosMin : psum);
    tsum = prod[39:0] + {8'b0, lo_q} + 40'd128;
    dh   = tsum[39:8];
  end

  // Sequencer next state
  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    in_ready_o = 1'b0;
    out_load   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) state_d = ST_CORDIC;
      end
      ST_CORDIC: begin
        if (cord_done) begin
          state_d = ST_MUL;
          op_d    = OP_PX;
        end
      end
      ST_MUL: state_d = ST_ACC;
      ST_ACC: begin
        if (op_q == OP_HI) begin
          state_d = ST_DONE;
        end else begin
          op_d    = op_e'(op_q + 4'd1);
          state_d = ST_MUL;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Hold control state, gains and pose
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= OP_PX;
      out_valid_q <= 1'b0;
      lin_gain_q  <= GainReset;
      ang_gain_q  <= GainReset;
      pos_x_q     <= '0;
      pos_y_q     <= '0;
      heading_q   <= '0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      if (out_load)         out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_LINEAR_GAIN:  lin_gain_q <= cfg_data_i;
          CFG_ANGULAR_GAIN: ang_gain_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (state_q == ST_ACC) begin
        if (op_q == OP_DX) pos_x_q <= pclamp[P-1:0];
        if (op_q == OP_DY) pos_y_q <= pclamp[P-1:0];
        if (op_q == OP_HI) heading_q <= step_q[54] ? heading_q - dh : heading_q + dh;
      end
    end
  end

  // Capture the word and the intermediate products, and load the output word
  always_ff @(posedge clk_i) begin
    if (accept) in_q <= in_data_i;
    if (state_q == ST_ACC) begin
      case (op_q)
        OP_PX:   px_q   <= prod[32:0];
        OP_PY:   py_q   <= prod[32:0];
        OP_PW:   pw_q   <= prod[32:0];
        OP_RX_C: acc_q  <= prod;
        OP_RX_S: rx_q   <= rnd30[33:0];
        OP_RY_S: acc_q  <= prod;
        OP_RY_C: ry_q   <= rnd30[33:0];
        OP_STEP: step_q <= prod[54:0];
        OP_LO:   lo_q   <= prod[63:32];
        default: ;
      endcase
    end
    if (out_load) begin
      out_q.position_x     <= pos_x_q;
      out_q.position_y     <= pos_y_q;
      out_q.heading_angle  <= heading_q;
      out_q.scaled_forward <= scale24(px_q);
      out_q.scaled_lateral <= scale24(py_q);
      out_q.scaled_yaw     <= scale24(pw_q);
      out_q.moving         <= (in_q.forward_speed != '0) || (in_q.yaw_rate != '0);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
